### design/wfba_pkg.sv
// ----------------------------------------------------------------------------
// wfba_pkg: shared types and constants for the worst-fit block allocator
// Table geometry, field widths, sequencer states and the table control bundle.
// ----------------------------------------------------------------------------
package wfba_pkg;

  // Table geometry
  localparam int MAX_BLOCKS = 16;
  localparam int SIZE_BITS  = 16;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);
  localparam int CNT_W      = $clog2(MAX_BLOCKS + 1);

  // Fixed field widths
  localparam int BCNT_W     = 5;
  localparam int BIDX_W     = 4;
  localparam int FSIZE_W    = 16;

  // Item kinds
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_ALLOC = 1'b1;

  // Register word indexes
  localparam logic REG_BLOCK_COUNT = 1'b0;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Control from sequencer to block table
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [SIZE_BITS-1:0] wr_size;
    logic             take_en;
    logic [IDX_W-1:0] take_addr;
    logic [IDX_W-1:0] rd_addr;
  } tbl_ctrl_t;

endpackage

### design/worst_fit_block_allocator.sv
// ----------------------------------------------------------------------------
// worst_fit_block_allocator: an allocate walks min(block_count,16) entries,
// one table entry per cycle through the single size-memory read port, then
// drains the compare stage (a zero count goes straight to the result).
// A load writes the table in idle; a new item is accepted again once the result is held.
// rst clears block_count, the taken flags and the sequencer; sizes need loading.
// ----------------------------------------------------------------------------
module worst_fit_block_allocator (
  input  logic        clk,
  input  logic        rst,
  // s_tdata: block_index[3:0], block_size[19:4], request_size[35:20], zero pad
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,
  // s_tuser: mode[0]
  input  logic        s_tuser,
  // m_tdata: chosen_block[3:0], leftover[19:4], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  // m_tuser: granted[0]
  output logic        m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [wfba_pkg::BCNT_W-1:0]    block_count;
  wfba_pkg::tbl_ctrl_t            tbl;
  logic [wfba_pkg::SIZE_BITS-1:0] rd_size;
  logic                           rd_taken;
  logic [wfba_pkg::BIDX_W-1:0]    out_block;
  logic [wfba_pkg::FSIZE_W-1:0]   out_left;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == wfba_pkg::REG_BLOCK_COUNT) ?
                  32'(block_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= '0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == wfba_pkg::REG_BLOCK_COUNT) begin
      block_count <= pwdata[wfba_pkg::BCNT_W-1:0];
    end
  end

  wfba_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .block_count (block_count),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_mode     (s_tuser),
    .in_index    (s_tdata[3:0]),
    .in_size     (s_tdata[19:4]),
    .in_req      (s_tdata[35:20]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_granted (m_tuser),
    .out_block   (out_block),
    .out_left    (out_left),
    .tbl         (tbl),
    .rd_size     (rd_size),
    .rd_taken    (rd_taken)
  );

  wfba_table u_table (
    .clk      (clk),
    .rst      (rst),
    .ctl      (tbl),
    .rd_size  (rd_size),
    .rd_taken (rd_taken)
  );

  // Pack the result
  assign m_tdata = {4'b0000, out_left, out_block};

endmodule

### design/wfba_table.sv
// ----------------------------------------------------------------------------
// wfba_table: block size memory and taken flags
// Sizes sit in a one-write, one-read memory with registered read data; taken
// flags are flip-flops cleared by reset and read alongside the size.
// ----------------------------------------------------------------------------
module wfba_table (
  input  logic                          clk,
  input  logic                          rst,
  input  wfba_pkg::tbl_ctrl_t           ctl,
  output logic [wfba_pkg::SIZE_BITS-1:0] rd_size,
  output logic                          rd_taken
);

  logic [wfba_pkg::SIZE_BITS-1:0] mem [wfba_pkg::MAX_BLOCKS];
  logic [wfba_pkg::MAX_BLOCKS-1:0] taken;

  // Write a loaded size
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_size;
    end
  end

  // Registered read of size and flag
  always_ff @(posedge clk) begin
    rd_size  <= mem[ctl.rd_addr];
    rd_taken <= taken[ctl.rd_addr];
  end

  // Free on load, mark on grant
  always_ff @(posedge clk) begin
    if (rst) begin
      taken <= '0;
    end else begin
      if (ctl.wr_en) begin
        taken[ctl.wr_addr] <= 1'b0;
      end
      if (ctl.take_en) begin
        taken[ctl.take_addr] <= 1'b1;
      end
    end
  end

endmodule

### design/wfba_scan.sv
// ----------------------------------------------------------------------------
// wfba_scan: allocation sequencer with one shared subtract-and-compare unit
// Walks the table one entry per cycle, keeps the best leftover so far and
// holds the result in an output register until it is taken.
// ----------------------------------------------------------------------------
module wfba_scan (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [wfba_pkg::BCNT_W-1:0]      block_count,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_mode,
  input  logic [wfba_pkg::BIDX_W-1:0]      in_index,
  input  logic [wfba_pkg::FSIZE_W-1:0]     in_size,
  input  logic [wfba_pkg::FSIZE_W-1:0]     in_req,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_granted,
  output logic [wfba_pkg::BIDX_W-1:0]      out_block,
  output logic [wfba_pkg::FSIZE_W-1:0]     out_left,
  output wfba_pkg::tbl_ctrl_t              tbl,
  input  logic [wfba_pkg::SIZE_BITS-1:0]   rd_size,
  input  logic                             rd_taken
);

  wfba_pkg::state_t state, state_next;

  logic [wfba_pkg::SIZE_BITS-1:0] req;
  logic [wfba_pkg::CNT_W-1:0]     limit;
  logic [wfba_pkg::CNT_W-1:0]     limit_next;
  logic [wfba_pkg::CNT_W-1:0]     cnt;
  logic                           cmp_valid;
  logic [wfba_pkg::IDX_W-1:0]     cmp_idx;
  logic                           found;
  logic [wfba_pkg::IDX_W-1:0]     best_idx;
  logic [wfba_pkg::SIZE_BITS-1:0] best_left;

  logic                           accept;
  logic                           start_alloc;
  logic                           last_issue;
  logic                           out_free;
  logic                           out_load;
  logic [wfba_pkg::SIZE_BITS:0]   diff;
  logic                           fits;
  logic                           better;

  // Clamp the scan length to the table depth
  always_comb begin
    if (block_count > wfba_pkg::BCNT_W'(wfba_pkg::MAX_BLOCKS)) begin
      limit_next = wfba_pkg::CNT_W'(wfba_pkg::MAX_BLOCKS);
    end else begin
      limit_next = wfba_pkg::CNT_W'(block_count);
    end
  end

  assign accept      = in_valid && in_ready;
  assign start_alloc = accept && (in_mode == wfba_pkg::MODE_ALLOC);
  assign last_issue  = (cnt == limit - wfba_pkg::CNT_W'(1));
  assign out_free    = !out_valid || out_ready;

  // Shared unit: leftover by subtraction, fit from the borrow, then compare
  assign diff   = {1'b0, rd_size} - {1'b0, req};
  assign fits   = !diff[wfba_pkg::SIZE_BITS];
  assign better = !found || (diff[wfba_pkg::SIZE_BITS-1:0] > best_left);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      wfba_pkg::ST_IDLE: begin
        if (start_alloc) begin
          if (limit_next == '0) begin
            state_next = wfba_pkg::ST_DONE;
          end else begin
            state_next = wfba_pkg::ST_SCAN;
          end
        end
      end
      wfba_pkg::ST_SCAN: begin
        if (last_issue) begin
          state_next = wfba_pkg::ST_DRAIN;
        end
      end
      wfba_pkg::ST_DRAIN: begin
        state_next = wfba_pkg::ST_DONE;
      end
      wfba_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = wfba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = wfba_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    in_ready      = 1'b0;
    out_load      = 1'b0;
    tbl.wr_en     = 1'b0;
    tbl.wr_addr   = in_index[wfba_pkg::IDX_W-1:0];
    tbl.wr_size   = wfba_pkg::SIZE_BITS'(in_size);
    tbl.take_en   = 1'b0;
    tbl.take_addr = best_idx;
    tbl.rd_addr   = cnt[wfba_pkg::IDX_W-1:0];
    case (state)
      wfba_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        tbl.wr_en = in_valid && (in_mode == wfba_pkg::MODE_LOAD);
      end
      wfba_pkg::ST_DONE: begin
        out_load    = out_free;
        tbl.take_en = out_free && found;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // State register and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= wfba_pkg::ST_IDLE;
      cmp_valid <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cmp_valid <= (state == wfba_pkg::ST_SCAN);
      if (start_alloc) begin
        found <= 1'b0;
      end else if (cmp_valid && !rd_taken && fits && better) begin
        found <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan datapath
  always_ff @(posedge clk) begin
    cmp_idx <= cnt[wfba_pkg::IDX_W-1:0];
    if (start_alloc) begin
      req   <= wfba_pkg::SIZE_BITS'(in_req);
      limit <= limit_next;
      cnt   <= '0;
    end else if (state == wfba_pkg::ST_SCAN) begin
      cnt <= cnt + wfba_pkg::CNT_W'(1);
    end
    if (cmp_valid && !rd_taken && fits && better) begin
      best_idx  <= cmp_idx;
      best_left <= diff[wfba_pkg::SIZE_BITS-1:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_granted <= found;
      out_block   <= found ? wfba_pkg::BIDX_W'(best_idx) : '0;
      out_left    <= found ? wfba_pkg::FSIZE_W'(best_left) : '0;
    end
  end

`ifndef NO_ASSERTIONS
  a_nogrant_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_granted |-> out_block == '0 && out_left == '0)
    else $error("refused result carries a nonzero index or leftover");

  a_cmp_window: assert property (@(posedge clk) disable iff (rst)
    cmp_valid |-> state == wfba_pkg::ST_SCAN || state == wfba_pkg::ST_DRAIN)
    else $error("compare active outside the scan");

  a_drain_done: assert property (@(posedge clk) disable iff (rst)
    state == wfba_pkg::ST_DRAIN |=> state == wfba_pkg::ST_DONE)
    else $error("drain did not lead to result");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    state == wfba_pkg::ST_DONE && found |-> wfba_pkg::CNT_W'(best_idx) < limit)
    else $error("chosen block beyond scanned range");
`endif

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Worst-fit block allocator testbench
// Streams block-size loads and allocate requests into the allocator over a
// valid/ready input, rewrites block_count over APB between phases, and checks
// every grant against a worst-fit predictor held in a scoreboard object.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SETTLE_CYCLES = 30;
  localparam int HOLD_CYCLES   = 300;
  localparam int MAX_PRINTED   = 40;

  // One allocation outcome as the block presents it
  typedef struct packed {
    logic        granted;
    logic [3:0]  chosen;
    logic [15:0] leftover;
  } grant_t;

  // Worst-fit table mirror and queue of grants still to arrive
  class worst_fit_tracker;
    logic [15:0] sizes [wfba_pkg::MAX_BLOCKS];
    bit          taken [wfba_pkg::MAX_BLOCKS];
    logic [4:0]  count;
    grant_t      pending_grants [$];
    int          mismatches;

    function new();
      foreach (taken[i]) taken[i] = 1'b0;
      foreach (sizes[i]) sizes[i] = '0;
      count      = '0;
      mismatches = 0;
    endfunction

    function int pending();
      return pending_grants.size();
    endfunction

    task report(string msg);
      if (mismatches < MAX_PRINTED) $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    // Apply one accepted item to the mirror; allocates queue their grant
    function void note_item(logic m, logic [3:0] idx, logic [15:0] sz,
                            logic [15:0] rq);
      grant_t      g;
      int          limit;
      bit          found;
      logic [3:0]  best;
      logic [15:0] best_left;
      if (m == wfba_pkg::MODE_LOAD) begin
        sizes[idx] = sz;
        taken[idx] = 1'b0;
        return;
      end
      limit     = (count > wfba_pkg::MAX_BLOCKS) ? wfba_pkg::MAX_BLOCKS : int'(count);
      found     = 1'b0;
      best      = '0;
      best_left = '0;
      for (int j = 0; j < limit; j++) begin
        if (!taken[j] && sizes[j] >= rq) begin
          if (!found || (sizes[j] - rq) > best_left) begin
            found     = 1'b1;
            best      = 4'(j);
            best_left = sizes[j] - rq;
          end
        end
      end
      if (found) taken[best] = 1'b1;
      g.granted  = found;
      g.chosen   = found ? best : 4'd0;
      g.leftover = found ? best_left : 16'd0;
      pending_grants.push_back(g);
    endfunction

    // Compare one delivered grant with the oldest one owed
    task check_grant(logic granted, logic [3:0] chosen, logic [15:0] leftover);
      grant_t g;
      if (pending_grants.size() == 0) begin
        report($sformatf("unexpected result granted=%b block=%0d leftover=%0d",
                         granted, chosen, leftover));
      end else begin
        g = pending_grants.pop_front();
        if (granted !== g.granted)
          report($sformatf("granted %b, want %b", granted, g.granted));
        if (chosen !== g.chosen)
          report($sformatf("chosen_block %0d, want %0d", chosen, g.chosen));
        if (leftover !== g.leftover)
          report($sformatf("leftover %0d, want %0d", leftover, g.leftover));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  worst_fit_tracker tracker = new();
  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  int hold_requests  = 0;

  worst_fit_block_allocator dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #2 clk = ~clk;

  // Offer one item, with random idle cycles ahead, and hold until the transfer
  task automatic send_item(logic m, logic [3:0] idx, logic [15:0] sz, logic [15:0] rq);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= m;
    s_tdata  <= {4'b0, rq, sz, idx};
    do @(posedge clk); while (!s_tready);
    tracker.note_item(m, idx, sz, rq);
  endtask

  // Drop valid, wait for every owed grant, then let a trailing load finish
  task automatic settle();
    s_tvalid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write of block_count: setup cycle, then access until pready
  task automatic write_block_count(logic [4:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(4 * wfba_pkg::REG_BLOCK_COUNT);
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.count = value;
  endtask

  // Random item: sizes are bunched at times so that ties and exact fits occur
  task automatic random_item();
    logic        m;
    logic [3:0]  idx;
    logic [15:0] sz;
    logic [15:0] rq;
    m   = ($urandom_range(99) < 55) ? wfba_pkg::MODE_ALLOC : wfba_pkg::MODE_LOAD;
    idx = 4'($urandom_range(15));
    sz  = 16'($urandom);
    rq  = 16'($urandom);
    if (m == wfba_pkg::MODE_LOAD) begin
      if ($urandom_range(1) == 0) sz = 16'($urandom_range(7) * 8);
    end else begin
      case ($urandom_range(9))
        0:          rq = 16'h0000;
        1:          rq = 16'hFFFF;
        2, 3, 4, 5: rq = 16'($urandom_range(64));
        default:    ;
      endcase
    end
    send_item(m, idx, sz, rq);
  endtask

  task automatic run_phase(logic [4:0] count, int src_pct, int sink_pct, int items,
                           bit hold);
    settle();
    write_block_count(count);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    if (hold) hold_requests++;
    repeat (items) random_item();
  endtask

  // Result side: check transfers, stall at random, hold off on request
  initial begin
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        tracker.check_grant(m_tuser, m_tdata[3:0], m_tdata[19:4]);
      if (holds_seen != hold_requests) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Stimulus and final verdict
  initial begin
    logic [15:0] seed_sizes [16];
    seed_sizes = '{16'h0000, 16'hFFFF, 16'h0064, 16'h0064, 16'h0064, 16'h5555,
                   16'hAAAA, 16'h0001, 16'h8000, 16'h7FFF, 16'h0040, 16'h0040,
                   16'h0003, 16'h0200, 16'hFFFE, 16'h0002};
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= wfba_pkg::MODE_LOAD;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zero count after reset: nothing can be granted
    send_item(wfba_pkg::MODE_ALLOC, 4'hF, 16'hFFFF, 16'h0000);
    send_item(wfba_pkg::MODE_ALLOC, 4'h0, 16'h0000, 16'hFFFF);

    // Fill the whole table before any scan can reach it
    for (int i = 0; i < wfba_pkg::MAX_BLOCKS; i++)
      send_item(wfba_pkg::MODE_LOAD, 4'(i), seed_sizes[i], 16'(~i));

    // Full table: exact fit at the top, zero requests, tied sizes
    settle();
    write_block_count(5'd16);
    send_item(wfba_pkg::MODE_ALLOC, 4'h0, 16'h0000, 16'hFFFF);
    send_item(wfba_pkg::MODE_ALLOC, 4'h0, 16'h0000, 16'h0000);
    send_item(wfba_pkg::MODE_ALLOC, 4'h0, 16'h0000, 16'h0064);
    send_item(wfba_pkg::MODE_LOAD,  4'h1, 16'hFFFF, 16'h0000);
    send_item(wfba_pkg::MODE_ALLOC, 4'hF, 16'hFFFF, 16'hFFFF);

    // Count above the table saturates to the full table
    settle();
    write_block_count(5'd31);
    send_item(wfba_pkg::MODE_ALLOC, 4'h0, 16'h0000, 16'h0000);
    send_item(wfba_pkg::MODE_ALLOC, 4'h0, 16'h0000, 16'h0064);

    // Random phases over counts and idling patterns
    run_phase(5'd16, 0, 0, 110, 1'b0);
    run_phase(5'($urandom_range(1, 15)), 79, 0, 110, 1'b0);
    run_phase(5'd31, 0, 79, 110, 1'b0);
    run_phase(5'd1, 38, 38, 60, 1'b0);
    run_phase(5'($urandom_range(31)), 0, 0, 40, 1'b1);
    run_phase(5'd0, 0, 0, 10, 1'b0);
    run_phase(5'd16, 38, 38, 110, 1'b0);

    settle();
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

endmodule
